### rtl/core/aawd_pkg.sv
// Shared types, constants and register map of the activity window detector.
package aawd_pkg;

  // Axis samples use the low AXIS_W bits, sign extended from the top one.
  localparam int unsigned AXIS_W = 16;

  localparam int unsigned SQ_W   = 32;   // sum of three squares
  localparam int unsigned MAG_W  = 16;   // floor of the square root
  localparam int unsigned IDX_W  = 32;   // sample counter and mark positions
  localparam int unsigned CNT_W  = 6;    // mark count
  localparam int unsigned ADDR_W = 5;

  localparam int unsigned SQRT_STEPS = SQ_W / 2;

  // Register indexes
  localparam logic [2:0] REG_MAG_LEVEL   = 3'd0;
  localparam logic [2:0] REG_JUMP_LEVEL  = 3'd1;
  localparam logic [2:0] REG_MIN_GAP     = 3'd2;
  localparam logic [2:0] REG_MAX_GAP     = 3'd3;
  localparam logic [2:0] REG_CAPTURE     = 3'd4;
  localparam logic [2:0] REG_MARK_LIMIT  = 3'd5;

  // Reset values
  localparam logic [15:0] RST_MAG_LEVEL  = 16'd1005;
  localparam logic [15:0] RST_JUMP_LEVEL = 16'd1200;
  localparam logic [15:0] RST_MIN_GAP    = 16'd30;
  localparam logic [14:0] RST_MAX_GAP    = 15'd400;
  localparam logic [15:0] RST_CAPTURE    = 16'd800;
  localparam logic [5:0]  RST_MARK_LIMIT = 6'd54;

  typedef struct packed {
    logic        [15:0] magnitude_level;
    logic        [15:0] jump_level;
    logic        [15:0] min_gap;
    logic        [14:0] max_gap;
    logic        [15:0] capture_samples;
    logic        [5:0]  mark_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               force_reset;
  } in_item_t;

  typedef struct packed {
    logic               capture;
    logic signed [15:0] begin_offset;
    logic signed [15:0] end_offset;
  } out_item_t;

endpackage

### rtl/core/aawd_cfg.sv
// APB-style register file for the detector thresholds.
module aawd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aawd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output aawd_pkg::cfg_t              cfg_o
);

  aawd_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        aawd_pkg::REG_MAG_LEVEL:  cfg_d.magnitude_level = pwdata[15:0];
        aawd_pkg::REG_JUMP_LEVEL: cfg_d.jump_level      = pwdata[15:0];
        aawd_pkg::REG_MIN_GAP:    cfg_d.min_gap         = pwdata[15:0];
        aawd_pkg::REG_MAX_GAP:    cfg_d.max_gap         = pwdata[14:0];
        aawd_pkg::REG_CAPTURE:    cfg_d.capture_samples = pwdata[15:0];
        aawd_pkg::REG_MARK_LIMIT: cfg_d.mark_limit      = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aawd_pkg::REG_MAG_LEVEL:  prdata = {16'd0, cfg_q.magnitude_level};
      aawd_pkg::REG_JUMP_LEVEL: prdata = {16'd0, cfg_q.jump_level};
      aawd_pkg::REG_MIN_GAP:    prdata = {16'd0, cfg_q.min_gap};
      aawd_pkg::REG_MAX_GAP:    prdata = {17'd0, cfg_q.max_gap};
      aawd_pkg::REG_CAPTURE:    prdata = {16'd0, cfg_q.capture_samples};
      aawd_pkg::REG_MARK_LIMIT: prdata = {26'd0, cfg_q.mark_limit};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magnitude_level <= aawd_pkg::RST_MAG_LEVEL;
      cfg_q.jump_level      <= aawd_pkg::RST_JUMP_LEVEL;
      cfg_q.min_gap         <= aawd_pkg::RST_MIN_GAP;
      cfg_q.max_gap         <= aawd_pkg::RST_MAX_GAP;
      cfg_q.capture_samples <= aawd_pkg::RST_CAPTURE;
      cfg_q.mark_limit      <= aawd_pkg::RST_MARK_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/aawd_sumsq.sv
// Sum of three axis squares: axes shift past one shared multiplier, one per cycle.
module aawd_sumsq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [15:0]               ax_i,
  input  logic [15:0]               ay_i,
  input  logic [15:0]               az_i,
  output logic                      done_o,
  output logic [aawd_pkg::SQ_W-1:0] sum_o
);

  logic [2:0][15:0]            axis_q, axis_d;
  logic [1:0]                  step_q, step_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [aawd_pkg::SQ_W-1:0]   prod_q, prod_d;
  logic [aawd_pkg::SQ_W-1:0]   acc_q, acc_d;
  logic signed [16:0]          ext;
  logic signed [16:0]          mag17;
  logic [15:0]                 mag;

  // sign extend from the axis width, then take the absolute value
  assign ext   = 17'(signed'(axis_q[0][aawd_pkg::AXIS_W-1:0]));
  assign mag17 = ext[16] ? -ext : ext;
  assign mag   = mag17[15:0];

  always_comb begin
    axis_d = axis_q;
    step_d = step_q;
    busy_d = busy_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (start_i) begin
      axis_d = {az_i, ay_i, ax_i};
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      axis_d = {16'd0, axis_q[2], axis_q[1]};
      prod_d = 32'(mag) * 32'(mag);
      acc_d  = (step_q == 2'd0) ? '0 : acc_q + prod_q;
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q <= axis_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign done_o = done_q;
  assign sum_o  = acc_q;

endmodule

### rtl/core/aawd_isqrt.sv
// Bit-serial integer square root: two radicand bits in, one root bit out per cycle.
module aawd_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [aawd_pkg::SQ_W-1:0]  rad_i,
  output logic                       done_o,
  output logic [aawd_pkg::MAG_W-1:0] root_o
);

  localparam int unsigned REM_W = aawd_pkg::MAG_W + 1;

  logic [aawd_pkg::SQ_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [aawd_pkg::MAG_W-1:0] root_q, root_d;
  logic [3:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [REM_W+1:0]           remx;
  logic [REM_W+1:0]           trial;
  logic [REM_W+1:0]           diff;

  assign remx  = {rem_q, rad_q[aawd_pkg::SQ_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign diff  = remx - trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[aawd_pkg::SQ_W-3:0], 2'b00};
      if (remx >= trial) begin
        rem_d  = diff[REM_W-1:0];
        root_d = {root_q[aawd_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_d  = remx[REM_W-1:0];
        root_d = {root_q[aawd_pkg::MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(aawd_pkg::SQRT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/core/aawd_track.sv
// Mark tracking, window capture decision and sample counter.
module aawd_track (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  aawd_pkg::cfg_t             cfg_i,
  input  logic                       commit_i,
  input  logic                       force_i,
  input  logic [aawd_pkg::MAG_W-1:0] mag_i,
  output aawd_pkg::out_item_t        res_o
);

  // the previous magnitude of a step is the current one held here
  logic [aawd_pkg::MAG_W-1:0] curr_q, curr_d;
  logic [aawd_pkg::IDX_W-1:0] idx_q, idx_d, first_q, first_d, last_q, last_d;
  logic [aawd_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic [aawd_pkg::MAG_W-1:0] jump;
  logic                       big_jump, loud, gap_ok, gap_clr, mark, cap;
  logic [aawd_pkg::IDX_W-1:0] gap, first1, last1, first2, last2, amount;
  logic [aawd_pkg::CNT_W-1:0] cnt1, cnt2;
  logic [15:0]                twice_max;

  assign twice_max = {cfg_i.max_gap, 1'b0};

  always_comb begin
    jump     = (mag_i > curr_q) ? mag_i - curr_q : curr_q - mag_i;
    big_jump = jump >= cfg_i.jump_level;
    loud     = (curr_q >= cfg_i.magnitude_level) || (mag_i >= cfg_i.magnitude_level);

    gap     = idx_q - last_q;
    gap_clr = (cnt_q != '0) && (gap >= 32'(twice_max));
    gap_ok  = (cnt_q == '0) ||
              ((gap >= 32'(cfg_i.min_gap)) && (gap <= 32'(cfg_i.max_gap)));

    cnt1   = gap_clr ? '0 : cnt_q;
    first1 = gap_clr ? '0 : first_q;
    last1  = gap_clr ? '0 : last_q;

    mark   = big_jump && loud && gap_ok;
    cnt2   = mark ? cnt1 + 6'd1 : cnt1;
    first2 = (mark && cnt1 == '0) ? idx_q : first1;
    last2  = mark ? idx_q : last1;

    amount = (last2 - first2) + 32'(cnt2) - 32'd1;
    cap    = (cnt2 >= 6'd2) && (amount >= 32'(cfg_i.capture_samples));

    curr_d  = mag_i;
    cnt_d   = cnt2;
    first_d = first2;
    last_d  = last2;
    idx_d   = idx_q + 32'd1;
    res_o   = '0;

    if (cap) begin
      res_o.capture      = 1'b1;
      res_o.begin_offset = signed'(16'(first2 - idx_q));
      res_o.end_offset   = signed'(16'(last2 - idx_q));
      cnt_d   = '0;
      first_d = '0;
      last_d  = '0;
      curr_d  = '0;
    end else if ((cnt2 >= 6'd2) && (cnt2 >= cfg_i.mark_limit)) begin
      cnt_d   = '0;
      first_d = '0;
      last_d  = '0;
    end

    if (force_i) begin
      res_o   = '0;
      curr_d  = '0;
      idx_d   = '0;
      cnt_d   = '0;
      first_d = '0;
      last_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curr_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else if (commit_i) begin
      curr_q  <= curr_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

endmodule

### rtl/core/accel_activity_window_detector_unit.sv
// Top level of the accelerometer activity window detector.
//
//  channel   signals                          direction
//  in        in_valid_i/in_ready_o/in_data_i  sample in, one per transfer
//  out       out_valid_o/out_ready_i/out_data_o  one result per sample
//  cfg       psel/penable/pwrite/paddr/pwdata/prdata/pready  registers
//
// A transferred sample passes the shared squaring multiplier, the root load,
// 16 root steps, the hand-over of the root and the decide.
// A force-reset sample skips the arithmetic and goes straight to the decide.
// One sample in flight; the next is taken once the result lands in the
// output register. A stalled output holds the decide.
// Reset is asynchronous, active low; control state clears at once, data registers do not.
module accel_activity_window_detector_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  aawd_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output aawd_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aawd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_RT   = 2'd2;
  localparam logic [1:0] ST_DEC  = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic                       force_q, force_d;
  logic                       out_valid_q, out_valid_d;
  aawd_pkg::out_item_t        out_q, out_d;
  aawd_pkg::out_item_t        res;
  aawd_pkg::cfg_t             cfg;
  logic                       in_xfer, sq_start, sq_done, rt_done, commit;
  logic [aawd_pkg::SQ_W-1:0]  sum;
  logic [aawd_pkg::MAG_W-1:0] mag;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign sq_start   = in_xfer && !in_data_i.force_reset;
  assign commit     = (state_q == ST_DEC) && (!out_valid_q || out_ready_i);

  aawd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  aawd_sumsq u_sumsq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .ax_i    (in_data_i.accel_x),
    .ay_i    (in_data_i.accel_y),
    .az_i    (in_data_i.accel_z),
    .done_o  (sq_done),
    .sum_o   (sum)
  );

  aawd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_done),
    .rad_i   (sum),
    .done_o  (rt_done),
    .root_o  (mag)
  );

  aawd_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .commit_i (commit),
    .force_i  (force_q),
    .mag_i    (mag),
    .res_o    (res)
  );

  always_comb begin
    state_d     = state_q;
    force_d     = force_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          force_d = in_data_i.force_reset;
          state_d = in_data_i.force_reset ? ST_DEC : ST_SQ;
        end
      end
      ST_SQ: begin
        if (sq_done) begin
          state_d = ST_RT;
        end
      end
      ST_RT: begin
        if (rt_done) begin
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        if (commit) begin
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      force_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      force_q     <= force_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/accel_activity_window_detector_unit_tb.sv
// Self-checking testbench for the accelerometer activity window detector.
module accel_activity_window_detector_unit_tb;
  import aawd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_AT     = 500;   // result count at which the long hold-off starts
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {SMP_QUIET, SMP_MID, SMP_LOUD, SMP_NOISE} sample_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_STALL, RX_HOLD} rx_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  in_item_t    in_data    = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  out_item_t   out_data;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  accel_activity_window_detector_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Predictor state and the register copy it works from
  cfg_t        cfg_now = '{RST_MAG_LEVEL, RST_JUMP_LEVEL, RST_MIN_GAP, RST_MAX_GAP,
                           RST_CAPTURE, RST_MARK_LIMIT};
  logic [15:0] prev_mag   = '0;
  logic [15:0] curr_mag   = '0;
  logic [31:0] smp_idx    = '0;
  logic [5:0]  mark_cnt   = '0;
  logic [31:0] first_mark = '0;
  logic [31:0] last_mark  = '0;

  in_item_t  sample_q[$];
  out_item_t expected_windows[$];

  int n_queued     = 0;
  int n_accepted   = 0;
  int results_seen = 0;
  int n_captures   = 0;
  int n_forced     = 0;
  int n_settings   = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  logic sample_taken = 1'b0;

  int burst_left = 1;
  int gap_left   = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int  rx_left   = 0;
  logic hold_done = 1'b0;
  logic rx_rdy;

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [15:0] floor_root(logic [31:0] v);
    logic [15:0] r;
    logic [15:0] t;
    logic [31:0] t_sq;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (16'd1 << b);
      t_sq = 32'(t) * 32'(t);
      if (t_sq <= v) r = t;
    end
    return r;
  endfunction

  function automatic void drop_marks();
    mark_cnt   = '0;
    first_mark = '0;
    last_mark  = '0;
  endfunction

  function automatic out_item_t predict_window(in_item_t s);
    out_item_t   r;
    int          ax, ay, az;
    logic [31:0] energy, gap, span;
    logic [15:0] jump;
    logic        gap_ok;
    r = '0;
    if (s.force_reset) begin
      prev_mag = '0;
      curr_mag = '0;
      smp_idx  = '0;
      drop_marks();
      return r;
    end
    ax = int'(s.accel_x);
    ay = int'(s.accel_y);
    az = int'(s.accel_z);
    energy = ax * ax + ay * ay + az * az;   // wraps into 32 bits, fits unsigned
    prev_mag = curr_mag;
    curr_mag = floor_root(energy);
    jump = (curr_mag > prev_mag) ? curr_mag - prev_mag : prev_mag - curr_mag;
    gap_ok = 1'b1;
    if (mark_cnt != 0) begin
      gap = smp_idx - last_mark;
      // a gap of twice the maximum clears, but still gates this sample
      if (gap >= {16'd0, cfg_now.max_gap, 1'b0}) drop_marks();
      gap_ok = (gap >= 32'(cfg_now.min_gap)) && (gap <= 32'(cfg_now.max_gap));
    end
    if (jump >= cfg_now.jump_level && gap_ok &&
        (prev_mag >= cfg_now.magnitude_level || curr_mag >= cfg_now.magnitude_level)) begin
      if (mark_cnt == 0) first_mark = smp_idx;
      last_mark = smp_idx;
      mark_cnt  = mark_cnt + 6'd1;
    end
    if (mark_cnt >= 6'd2) begin
      span = (last_mark - first_mark) + 32'(mark_cnt) - 32'd1;
      if (span >= 32'(cfg_now.capture_samples)) begin
        r.capture      = 1'b1;
        r.begin_offset = 16'(first_mark - smp_idx);
        r.end_offset   = 16'(last_mark - smp_idx);
        drop_marks();
        prev_mag = '0;
        curr_mag = '0;
      end else if (mark_cnt >= cfg_now.mark_limit) begin
        drop_marks();
      end
    end
    smp_idx = smp_idx + 32'd1;
    return r;
  endfunction

  function automatic in_item_t sample_of(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                         logic fr);
    in_item_t s;
    s.accel_x     = x;
    s.accel_y     = y;
    s.accel_z     = z;
    s.force_reset = fr;
    return s;
  endfunction

  function automatic in_item_t make_sample(sample_kind_e kind);
    in_item_t    s;
    int          lead;
    logic [15:0] lead_v;
    s = sample_of(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    if (kind == SMP_NOISE) return s;
    s.accel_x = 16'(int'($urandom_range(0, 600)) - 300);
    s.accel_y = 16'(int'($urandom_range(0, 600)) - 300);
    s.accel_z = 16'(int'($urandom_range(0, 600)) - 300);
    if (kind == SMP_QUIET) return s;
    lead = (kind == SMP_LOUD) ? int'($urandom_range(25000, 32767))
                              : int'($urandom_range(300, 9000));
    lead_v = $urandom_range(0, 1) ? 16'(-lead) : 16'(lead);
    if (kind == SMP_LOUD) begin
      s.accel_y = 16'(int'($urandom_range(0, 40000)) - 20000);
      s.accel_z = 16'(int'($urandom_range(0, 40000)) - 20000);
    end
    case ($urandom_range(0, 2))
      0: s.accel_x = lead_v;
      1: s.accel_y = lead_v;
      default: s.accel_z = lead_v;
    endcase
    return s;
  endfunction

  function automatic cfg_t mk_cfg(int mag, int jump, int ming, int maxg, int cap, int lim);
    cfg_t c;
    c.magnitude_level = 16'(mag);
    c.jump_level      = 16'(jump);
    c.min_gap         = 16'(ming);
    c.max_gap         = 15'(maxg);
    c.capture_samples = 16'(cap);
    c.mark_limit      = 6'(lim);
    return c;
  endfunction

  // Small windows so that marks, captures, drops and gap clears all happen often
  function automatic cfg_t busy_cfg();
    int ming, lim;
    ming = $urandom_range(0, 4);
    case ($urandom_range(0, 3))
      0: lim = 2;
      1: lim = 54;
      default: lim = $urandom_range(2, 54);
    endcase
    return mk_cfg($urandom_range(500, 20000), $urandom_range(300, 15000), ming,
                  ming + int'($urandom_range(0, 10)), $urandom_range(0, 60), lim);
  endfunction

  task automatic push_sample(in_item_t s);
    sample_q.push_back(s);
    n_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || expected_windows.size() != 0);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_regs(cfg_t c);
    logic [2:0]  idx [6];
    logic [31:0] val [6];
    idx = '{REG_MAG_LEVEL, REG_JUMP_LEVEL, REG_MIN_GAP, REG_MAX_GAP, REG_CAPTURE,
            REG_MARK_LIMIT};
    val = '{32'(c.magnitude_level), 32'(c.jump_level), 32'(c.min_gap), 32'(c.max_gap),
            32'(c.capture_samples), 32'(c.mark_limit)};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx[i], 2'b00};
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      if (prdata !== val[i]) flag_mismatch($sformatf("register %0d readback", idx[i]),
                                           prdata, val[i]);
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic program_regs(cfg_t c);
    apb_write(REG_MAG_LEVEL,  32'(c.magnitude_level));
    apb_write(REG_JUMP_LEVEL, 32'(c.jump_level));
    apb_write(REG_MIN_GAP,    32'(c.min_gap));
    apb_write(REG_MAX_GAP,    32'(c.max_gap));
    apb_write(REG_CAPTURE,    32'(c.capture_samples));
    apb_write(REG_MARK_LIMIT, 32'(c.mark_limit));
    cfg_now = c;
    n_settings++;
    check_regs(c);
  endtask

  // Mostly quiet runs ending in a strong sample, spaced inside the gap window,
  // with out-of-window spacing, noise, forced clears and long silences mixed in
  task automatic queue_activity(int n);
    int made, spacing, lo, hi, pick;
    made = 0;
    lo = (cfg_now.min_gap > 16'd40) ? 40 : ((cfg_now.min_gap == 0) ? 1 : int'(cfg_now.min_gap));
    hi = (cfg_now.max_gap > 15'd40) ? 40 : int'(cfg_now.max_gap);
    if (hi < lo) hi = lo;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 6) == 0) spacing = hi + int'($urandom_range(1, hi + 3));
        else spacing = $urandom_range(lo, hi);
        repeat (spacing - 1) push_sample(make_sample(SMP_QUIET));
        push_sample(make_sample($urandom_range(0, 9) < 7 ? SMP_LOUD : SMP_MID));
        made += spacing;
      end else if (pick < 95) begin
        push_sample(make_sample(SMP_NOISE));
        made++;
      end else if (pick < 97) begin
        push_sample(sample_of(16'($urandom), 16'($urandom), 16'($urandom), 1'b1));
        made++;
      end else begin
        spacing = $urandom_range(1, 70);
        repeat (spacing) push_sample(make_sample(SMP_QUIET));
        made += spacing;
      end
    end
  endtask

  // Sample driver: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sample_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_data  <= sample_q.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: open, choppy and stalled stretches, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        rx_mode   = RX_HOLD;
        rx_left   = HOLD_CYCLES;
      end else if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = (rx_mode == RX_STALL) ? $urandom_range(1, 25) : $urandom_range(1, 40);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   rx_rdy = 1'b1;
        RX_CHOPPY: rx_rdy = ($urandom_range(0, 4) != 0);
        default:   rx_rdy = 1'b0;
      endcase
      out_ready <= rx_rdy;
    end
  end

  // Monitor: predict on each sample transfer, compare on each result transfer
  always @(posedge clk) begin
    out_item_t want;
    cycle_cnt    <= cycle_cnt + 1;
    sample_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = predict_window(in_data);
        expected_windows.push_back(want);
        n_accepted++;
        if (in_data.force_reset) n_forced++;
        if (want.capture) n_captures++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_windows.size() == 0) begin
          flag_mismatch("result with nothing pending", 32'(out_data), 32'd0);
        end else begin
          want = expected_windows.pop_front();
          if (out_data.capture !== want.capture)
            flag_mismatch("capture", 32'(out_data.capture), 32'(want.capture));
          if (out_data.begin_offset !== want.begin_offset)
            flag_mismatch("begin_offset", 32'(out_data.begin_offset), 32'(want.begin_offset));
          if (out_data.end_offset !== want.end_offset)
            flag_mismatch("end_offset", 32'(out_data.end_offset), 32'(want.end_offset));
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(negedge clk);
    $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
             expected_windows.size());
    $display("** accel_activity_window_detector_unit: FAILED **");
    $finish;
  end

  initial begin
    cfg_t next_cfg;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_regs(cfg_now);

    // Axis extremes and forced clears under the reset settings
    push_sample(sample_of(16'h8000, 16'h8000, 16'h8000, 1'b0));
    push_sample(sample_of(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
    push_sample(sample_of(16'h0000, 16'h0000, 16'h0000, 1'b0));
    push_sample(sample_of(16'h8000, 16'h7FFF, 16'h0000, 1'b0));
    push_sample(sample_of(16'h0001, 16'hFFFF, 16'h0001, 1'b0));
    push_sample(sample_of(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1));
    push_sample(sample_of(16'h7FFF, 16'h0000, 16'h0000, 1'b0));
    push_sample(sample_of(16'h0000, 16'h8000, 16'h0000, 1'b0));
    push_sample(sample_of(16'h0000, 16'h0000, 16'h7FFF, 1'b0));
    push_sample(sample_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    push_sample(sample_of(16'h5555, 16'hAAAA, 16'h5555, 1'b0));
    push_sample(sample_of(16'h0000, 16'h0000, 16'h0000, 1'b1));
    wait_drained();

    // Tight window: marks, a capture, then a silence long enough to clear
    program_regs(mk_cfg(1000, 1000, 1, 3, 5, 54));
    push_sample(make_sample(SMP_LOUD));
    push_sample(make_sample(SMP_QUIET));
    push_sample(make_sample(SMP_LOUD));
    push_sample(make_sample(SMP_QUIET));
    push_sample(make_sample(SMP_QUIET));
    push_sample(make_sample(SMP_LOUD));
    repeat (6) push_sample(make_sample(SMP_QUIET));
    push_sample(make_sample(SMP_LOUD));
    push_sample(sample_of(16'h1234, 16'hEDCB, 16'h7FFF, 1'b1));

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: next_cfg = mk_cfg(0, 0, 0, 0, 0, 2);
        1: next_cfg = mk_cfg(65535, 65535, 65535, 32767, 65535, 54);
        2: next_cfg = mk_cfg(RST_MAG_LEVEL, RST_JUMP_LEVEL, RST_MIN_GAP, RST_MAX_GAP,
                             RST_CAPTURE, RST_MARK_LIMIT);
        default: next_cfg = busy_cfg();
      endcase
      if (ph == 3) next_cfg.mark_limit = 6'd1;   // below two: a second mark that does not capture drops
      wait_drained();
      repeat (4) @(negedge clk);
      program_regs(next_cfg);
      queue_activity(ph == 1 ? 60 : (ph < 3 ? 150 : 166));
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Checked %0d samples (%0d forced clears, %0d windows captured) over %0d settings,",
             n_accepted, n_forced, n_captures, n_settings);
    $display("with bursty input, choppy output and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("** accel_activity_window_detector_unit: PASSED **");
    end else begin
      $display("** accel_activity_window_detector_unit: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/aawd_pkg.sv
rtl/core/aawd_cfg.sv
rtl/core/aawd_sumsq.sv
rtl/core/aawd_isqrt.sv
rtl/core/aawd_track.sv
rtl/core/accel_activity_window_detector_unit.sv
tb/sv/accel_activity_window_detector_unit_tb.sv
